// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// Byte substitution tables, GF(2^8) helpers and register indexes.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 8'd0,
    REG_KEY_LOW  = 8'd1
  } cfg_reg_e;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8), reduction polynomial 0x11b
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

endpackage

// ===== hw/rtl/aes128_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher engine
// Iterative single-block encrypt/decrypt with stored round keys.
// ----------------------------------------------------------------------------
// The accepting edge loads the block with the first key addition; then each
// round runs in turn through the single shared round unit. Once the result
// is taken the engine is ready again; until then no new block is accepted.
// After reset or a key write, a sequencer expands the round keys. It reuses
// one key-schedule step per cycle; while it runs, no block is accepted. The
// key port stays open; the user must see that keys are written only while
// no block is in flight, which the block itself does not enforce. s_axis
// tdata: block_high [63:0], block_low [127:64]; tuser: func. m_axis tdata:
// result_high [63:0], result_low [127:64].
module aes128_block_cipher_top
  import aes_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [HalfW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [BlockW-1:0]   s_axis_tdata,   // block_high, block_low
  input  logic                s_axis_tuser,   // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [BlockW-1:0]   m_axis_tdata    // result_high, result_low
);

  typedef enum logic [1:0] {ST_EXPAND, ST_IDLE, ST_RUN, ST_OUT} state_e;

  state_e             state_q;
  logic [3:0]         cnt_q;
  logic [7:0]         rcon_q;
  logic [BlockW-1:0]  key_q;      // key_high in upper half
  logic [BlockW-1:0]  gen_q;      // round key being generated
  logic [BlockW-1:0]  rk_mem [NumRounds+1];
  logic [BlockW-1:0]  st_q;
  logic               inv_q;
  logic [BlockW-1:0]  rk_rd;
  logic [BlockW-1:0]  gen_next;
  logic [BlockW-1:0]  rnd_out;
  logic [BlockW-1:0]  in_blk;
  logic               cfg_hit;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {st_q[HalfW-1:0], st_q[BlockW-1:HalfW]};
  assign in_blk        = {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]};
  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == REG_KEY_HIGH || cfg_index_i == REG_KEY_LOW);

  // Key schedule step: next round key from the previous one
  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    w0 = gen_q[127:96]; w1 = gen_q[95:64]; w2 = gen_q[63:32]; w3 = gen_q[31:0];
    t  = {FWD_BOX[w3[23:16]] ^ rcon_q, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]],
          FWD_BOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    gen_next = {w0, w1, w2, w3};
  end

  // Round key read: encrypt counts up from 1, decrypt down from 9
  always_comb begin
    rk_rd = rk_mem[cnt_q];
  end

  aes_round u_round (
    .inv_i   (inv_q),
    .mix_i   (inv_q ? (cnt_q != 4'd0) : (cnt_q != 4'(NumRounds))),
    .state_i (st_q),
    .rkey_i  (rk_rd),
    .state_o (rnd_out)
  );

  // Round key store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXPAND) begin
      rk_mem[cnt_q] <= gen_q;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXPAND;
      cnt_q   <= '0;
      rcon_q  <= 8'h01;
      key_q   <= '0;
      gen_q   <= '0;
      st_q    <= '0;
      inv_q   <= 1'b0;
    end else begin
      if (cfg_hit) begin
        // restart expansion from the updated key
        if (cfg_index_i == REG_KEY_HIGH) begin
          key_q[BlockW-1:HalfW] <= cfg_data_i;
          gen_q <= {cfg_data_i, key_q[HalfW-1:0]};
        end else begin
          key_q[HalfW-1:0] <= cfg_data_i;
          gen_q <= {key_q[BlockW-1:HalfW], cfg_data_i};
        end
        state_q <= ST_EXPAND;
        cnt_q   <= '0;
        rcon_q  <= 8'h01;
      end else begin
        unique case (state_q)
          ST_EXPAND: begin
            gen_q  <= gen_next;
            rcon_q <= xtime(rcon_q);
            if (cnt_q == 4'(NumRounds)) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 4'd1;
            end
          end
          ST_IDLE: begin
            if (s_axis_tvalid) begin
              inv_q   <= s_axis_tuser;
              st_q    <= in_blk ^ rk_mem[s_axis_tuser ? 4'(NumRounds) : 4'd0];
              cnt_q   <= s_axis_tuser ? 4'(NumRounds - 1) : 4'd1;
              state_q <= ST_RUN;
            end
          end
          ST_RUN: begin
            st_q <= rnd_out;
            if (inv_q ? (cnt_q == 4'd0) : (cnt_q == 4'(NumRounds))) begin
              state_q <= ST_OUT;
            end else begin
              cnt_q <= inv_q ? cnt_q - 4'd1 : cnt_q + 4'd1;
            end
          end
          ST_OUT: begin
            if (m_axis_tready) begin
              state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES shared round unit
// One forward or inverse round on the 128-bit state, with the round key added.
// ----------------------------------------------------------------------------
module aes_round
  import aes_pkg::*;
(
  input  logic              inv_i,      // 1: inverse round
  input  logic              mix_i,      // apply (inverse) mix columns
  input  logic [BlockW-1:0] state_i,
  input  logic [BlockW-1:0] rkey_i,
  output logic [BlockW-1:0] state_o
);

  logic [7:0] sr [16];
  logic [7:0] sb [16];
  logic [7:0] ak [16];
  logic [7:0] mx [16];

  // Forward: sub, shift, mix, add key. Inverse: shift, sub, add key, mix.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c+r] = get_byte(state_i, 4*(inv_i ? ((c - r + 4) & 3) : ((c + r) & 3)) + r);
        sb[4*c+r] = inv_i ? INV_BOX[sr[4*c+r]] : FWD_BOX[sr[4*c+r]];
      end
    end
    for (int i = 0; i < 16; i++) begin
      ak[i] = inv_i ? (sb[i] ^ get_byte(rkey_i, i)) : sb[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, x1, x2, x4, y1, y2, y4, z1, z2, z4, w1, w2, w4;
        a0 = ak[4*c+r];
        a1 = ak[4*c+((r+1)&3)];
        a2 = ak[4*c+((r+2)&3)];
        a3 = ak[4*c+((r+3)&3)];
        x1 = xtime(a0); x2 = xtime(x1); x4 = xtime(x2);
        y1 = xtime(a1); y2 = xtime(y1); y4 = xtime(y2);
        z1 = xtime(a2); z2 = xtime(z1); z4 = xtime(z2);
        w1 = xtime(a3); w2 = xtime(w1); w4 = xtime(w2);
        if (inv_i) begin
          // 0e a0 ^ 0b a1 ^ 0d a2 ^ 09 a3
          mx[4*c+r] = (x4 ^ x2 ^ x1) ^ (y4 ^ y1 ^ a1) ^ (z4 ^ z2 ^ a2) ^ (w4 ^ a3);
        end else begin
          mx[4*c+r] = x1 ^ (y1 ^ a1) ^ a2 ^ a3;
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_o[BlockW-1-8*i -: 8] = (mix_i ? mx[i] : ak[i]) ^
                                   (inv_i ? 8'h00 : get_byte(rkey_i, i));
    end
  end

endmodule

// ===== hw/rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// AES port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker
  import aes_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [BlockW-1:0] m_axis_tdata
);

  // never accepting while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready with result pending");

  // accepted transaction: busy next cycle, no result yet
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !m_axis_tvalid))
    else $error("not busy after accept");

  // result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");

  // after delivery the result is not presented again
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result repeated");

endmodule

bind aes128_block_cipher_top aes_checker u_aes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/aes128_block_cipher_top_test.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher engine testbench
// Streams encrypt and decrypt blocks through the engine under several keys
// and idle patterns, predicts every result with a behavioral AES-128 and
// checks each output transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aes128_block_cipher_top_test;
  import aes_pkg::*;

  localparam bit FuncEnc = 1'b0;
  localparam bit FuncDec = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgBadIdx = 8'd7;
  localparam int unsigned SettleCycles = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [HalfW-1:0]  cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [BlockW-1:0] s_axis_tdata = '0;   // block_high, block_low
  logic              s_axis_tuser = 1'b0; // func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [BlockW-1:0] m_axis_tdata;        // result_high, result_low

  aes128_block_cipher_top dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [HalfW-1:0]  key_hi_q, key_lo_q;
  logic [BlockW-1:0] rkeys [11];
  logic [BlockW-1:0] expected_blocks [$];
  int unsigned       errors = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  bit                hold_recv = 1'b0;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // Key schedule from the current key registers into the round key table
  function automatic void expand_round_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] tmp, rcon;
    logic [BlockW-1:0] k;
    k = {key_hi_q, key_lo_q};
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = k[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = w[i-4+j];
      if (i % 16 == 0) begin
        tmp = t[0];
        t[0] = FWD_BOX[t[1]] ^ rcon;
        t[1] = FWD_BOX[t[2]];
        t[2] = FWD_BOX[t[3]];
        t[3] = FWD_BOX[tmp];
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) rkeys[r][127-8*i -: 8] = w[16*r+i];
  endfunction

  // Full 10-round cipher or inverse cipher of one block
  function automatic logic [BlockW-1:0] aes_block(bit dec, logic [BlockW-1:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [7:0] m0, m1, m2, m3;
    int rnd;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rkeys[dec ? 10 : 0][127-8*i -: 8];
    m0 = dec ? 8'h0e : 8'h02; m1 = dec ? 8'h0b : 8'h03;
    m2 = dec ? 8'h0d : 8'h01; m3 = dec ? 8'h09 : 8'h01;
    for (int n = 1; n <= 10; n++) begin
      rnd = dec ? 10 - n : n;
      t = s;
      // sub bytes and shift rows (order commutes)
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[4*c+r] = dec ? INV_BOX[t[4*((c-r+4)%4)+r]] : FWD_BOX[t[4*((c+r)%4)+r]];
      if (dec)
        for (int i = 0; i < 16; i++) s[i] ^= rkeys[rnd][127-8*i -: 8];
      if (n != 10)
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
          for (int r = 0; r < 4; r++)
            s[4*c+r] = gmul(a[r], m0) ^ gmul(a[(r+1)%4], m1)
                     ^ gmul(a[(r+2)%4], m2) ^ gmul(a[(r+3)%4], m3);
        end
      if (!dec)
        for (int i = 0; i < 16; i++) s[i] ^= rkeys[rnd][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) aes_block[127-8*i -: 8] = s[i];
  endfunction

  // One block transaction; prediction taken at acceptance
  task automatic send_block(bit dec, logic [HalfW-1:0] hi, logic [HalfW-1:0] lo);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= dec;
    s_axis_tdata  <= {lo, hi};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_blocks.push_back(aes_block(dec, {hi, lo}));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_blocks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [HalfW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else if (idx == REG_KEY_LOW) key_lo_q = val;
    expand_round_keys();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [HalfW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: random stall and result check
  always @(negedge clk_i)
    m_axis_tready <= !hold_recv &&
                     !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    logic [BlockW-1:0] exp_blk;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_blocks.size() == 0) begin
        $error("result with no block pending: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (m_axis_tdata[63:0] !== exp_blk[127:64]) begin
          $error("result_high exp %h got %h", exp_blk[127:64], m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[127:64] !== exp_blk[63:0]) begin
          $error("result_low exp %h got %h", exp_blk[63:0], m_axis_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  // Directed: zero key after reset, standard vector, extremes, both functions
  task automatic test_directed();
    send_block(FuncEnc, '0, '0);
    send_block(FuncDec, '0, '0);
    send_block(FuncEnc, '1, '1);
    send_block(FuncDec, '1, '1);
    wait_drained();
    write_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(FuncEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FuncDec, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(FuncEnc, 64'h8000000000000000, 64'h0000000000000001);
    send_block(FuncDec, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    wait_drained();
    // write to an unknown index leaves the keys alone
    write_reg(CfgBadIdx, '1);
    send_block(FuncEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_drained();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    send_block(FuncEnc, '0, '1);
    send_block(FuncDec, '1, '0);
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int n);
    logic [HalfW-1:0] hi, lo;
    bit dec;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_reg(REG_KEY_HIGH, rand64());
    write_reg(REG_KEY_LOW, rand64());
    for (int i = 0; i < n; i++) begin
      dec = 1'($urandom_range(1));
      hi = rand64();
      lo = rand64();
      // round-trip pairs: at times the opposite function is applied to the result
      send_block(dec, hi, lo);
      if ($urandom_range(3) == 0) begin
        logic [BlockW-1:0] c;
        c = aes_block(dec, {hi, lo});
        send_block(!dec, c[127:64], c[63:0]);
        i++;
      end
    end
    wait_drained();
  endtask

  // Receiver held off while sender keeps offering; then receiver is released
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_block(1'($urandom_range(1)), rand64(), rand64());
    join
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phase(0, 0, 260);
    test_random_phase(52, 0, 250);
    test_random_phase(0, 52, 250);
    test_random_phase(38, 38, 250);
    test_backpressure();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    key_hi_q = '0;
    key_lo_q = '0;
    expand_round_keys();
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/aes_pkg.sv
hw/rtl/aes_round.sv
hw/rtl/aes128_block_cipher_top.sv
hw/rtl/aes_checker.sv
bench/aes128_block_cipher_top_test.sv
